/* rtl/jmip_pkg.sv */
// Shared types and constants for the JPEG marker insert point finder.
package jmip_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned ResultW = 32;
  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_MANY = 2'd1,
    STATUS_TRUNC    = 2'd2,
    STATUS_BAD_LEN  = 2'd3
  } status_e;

  localparam logic [15:0] MarkerSoi  = 16'hFFD8;
  localparam logic [15:0] MarkerEoi  = 16'hFFD9;
  localparam logic [15:0] MarkerSos  = 16'hFFDA;
  localparam logic [15:0] MarkerApp0 = 16'hFFE0;
  localparam logic [15:0] MarkerApp1 = 16'hFFE1;
  localparam logic [15:0] MarkerApp2 = 16'hFFE2;
  localparam logic [7:0]  ByteFill   = 8'hFF;
  localparam logic [7:0]  ByteEoiLo  = 8'hD9;

  localparam logic [7:0]  MaxMarkersReset = 8'd100;
  localparam logic [7:0]  MarkersSat      = 8'd255;

endpackage

/* rtl/jmip_in_if.sv */
// Byte stream channel carrying one file byte per request.
interface jmip_in_if;
  logic                          valid;
  logic                          ready;
  logic [jmip_pkg::DataW-1:0]    data_byte;
  logic                          last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/jmip_out_if.sv */
// Result channel carrying the insert offset and the parse status.
interface jmip_out_if;
  logic                           valid;
  logic                           ready;
  logic [jmip_pkg::ResultW-1:0]   insert_offset;
  logic [jmip_pkg::StatusW-1:0]   status;

  modport source (output valid, output insert_offset, output status, input ready);
  modport sink   (input valid, input insert_offset, input status, output ready);
endinterface

/* rtl/jpeg_marker_insert_point_finder.sv */
// Top level: JPEG marker walk that finds the offset for a new APP segment.
//
//  Channel  Direction  Payload                        Request moves
//  in_i     sink       data_byte[7:0], last_byte      one file byte
//  out_o    source     insert_offset[31:0], status    one result per file
//  cfg      write      cfg_data_i[7:0] (max_markers)  on cfg_we_i
//
// One byte is taken per cycle; the parse state and the result register update
// at the same edge, so a result appears in the cycle after the byte that causes it.
// in_i.ready is low only while a held result is not taken, since the single
// output register is the only buffer. Reset loads max_markers with 100 and
// arms the parser; the final byte of a file rearms it the same way.
module jpeg_marker_insert_point_finder #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  jmip_in_if.sink                    in_i,
  jmip_out_if.source                 out_o,
  input  logic                       cfg_we_i,
  input  logic [jmip_pkg::DataW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    PH_MARK_HI,
    PH_MARK_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP,
    PH_SCAN,
    PH_SCAN_FF,
    PH_DONE
  } phase_e;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  phase_e         phase_q, phase_d;
  offset_t        pos_q, pos_d;
  logic [15:0]    marker_q, marker_d;
  logic [7:0]     len_hi_q, len_hi_d;
  logic [15:0]    skip_q, skip_d;
  offset_t        app12_q, app12_d;
  offset_t        app0_q, app0_d;
  logic [7:0]     seen_q, seen_d;
  logic [7:0]     max_markers_q;

  logic                              out_valid_q;
  logic [jmip_pkg::ResultW-1:0]      out_offset_q;
  jmip_pkg::status_e                 out_status_q;

  logic              accept;
  logic              emit;
  jmip_pkg::status_e emit_status;
  logic [15:0]       code_now;
  logic [15:0]       seg_len;
  offset_t           seg_end;
  offset_t           app_sel;
  logic [7:0]        b;

  assign b          = in_i.data_byte;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign code_now = {marker_q[15:8], b};
  assign seg_len  = {len_hi_q, b};
  // The first length byte sits one position before the current byte.
  assign seg_end  = pos_q - OFFSET_BITS'(1) + OFFSET_BITS'(seg_len);
  assign app_sel  = (app12_q != '0) ? app12_q : app0_q;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    marker_d    = marker_q;
    len_hi_d    = len_hi_q;
    skip_d      = skip_q;
    app12_d     = app12_q;
    app0_d      = app0_q;
    seen_d      = seen_q;
    emit        = 1'b0;
    emit_status = jmip_pkg::STATUS_OK;

    if (accept) begin
      case (phase_q)
        PH_MARK_HI: begin
          marker_d = {b, 8'h00};
          phase_d  = PH_MARK_LO;
        end
        PH_MARK_LO: begin
          marker_d = code_now;
          if (seen_q > max_markers_q) begin
            emit        = 1'b1;
            emit_status = jmip_pkg::STATUS_TOO_MANY;
          end else begin
            if (seen_q != jmip_pkg::MarkersSat) begin
              seen_d = seen_q + 8'd1;
            end
            if (code_now == jmip_pkg::MarkerSoi) begin
              phase_d = PH_MARK_HI;
            end else if (code_now == jmip_pkg::MarkerEoi) begin
              emit = 1'b1;
            end else begin
              phase_d = PH_LEN_HI;
            end
          end
        end
        PH_LEN_HI: begin
          len_hi_d = b;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (seg_len < 16'd2) begin
            emit        = 1'b1;
            emit_status = jmip_pkg::STATUS_BAD_LEN;
          end else begin
            if (marker_q == jmip_pkg::MarkerApp0) begin
              app0_d = seg_end;
            end else if (marker_q == jmip_pkg::MarkerApp1 ||
                         marker_q == jmip_pkg::MarkerApp2) begin
              app12_d = seg_end;
            end
            skip_d = seg_len - 16'd2;
            if (seg_len != 16'd2) begin
              phase_d = PH_SKIP;
            end else if (marker_q == jmip_pkg::MarkerSos) begin
              phase_d = PH_SCAN;
            end else begin
              phase_d = PH_MARK_HI;
            end
          end
        end
        PH_SKIP: begin
          if (skip_q != 16'd0) begin
            skip_d = skip_q - 16'd1;
          end
          if (skip_q == 16'd0 || skip_q == 16'd1) begin
            phase_d = (marker_q == jmip_pkg::MarkerSos) ? PH_SCAN : PH_MARK_HI;
          end
        end
        PH_SCAN: begin
          if (b == jmip_pkg::ByteFill) begin
            phase_d = PH_SCAN_FF;
          end
        end
        PH_SCAN_FF: begin
          // Fill bytes keep the search armed; anything but EOI or a fill byte resumes it.
          if (b == jmip_pkg::ByteEoiLo) begin
            marker_d = jmip_pkg::MarkerEoi;
            emit     = 1'b1;
          end else if (b != jmip_pkg::ByteFill) begin
            phase_d = PH_SCAN;
          end
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase

      if (emit) begin
        phase_d = PH_DONE;
      end

      pos_d = pos_q + OFFSET_BITS'(1);

      if (in_i.last_byte) begin
        if (!emit && phase_d != PH_DONE) begin
          emit        = 1'b1;
          emit_status = jmip_pkg::STATUS_TRUNC;
        end
        phase_d  = PH_MARK_HI;
        pos_d    = '0;
        marker_d = '0;
        len_hi_d = '0;
        skip_d   = '0;
        app12_d  = '0;
        app0_d   = '0;
        seen_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_MARK_HI;
      pos_q         <= '0;
      marker_q      <= '0;
      len_hi_q      <= '0;
      skip_q        <= '0;
      app12_q       <= '0;
      app0_q        <= '0;
      seen_q        <= '0;
      max_markers_q <= jmip_pkg::MaxMarkersReset;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      marker_q <= marker_d;
      len_hi_q <= len_hi_d;
      skip_q   <= skip_d;
      app12_q  <= app12_d;
      app0_q   <= app0_d;
      seen_q   <= seen_d;
      if (cfg_we_i) begin
        max_markers_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= emit_status;
      out_offset_q <= (emit_status == jmip_pkg::STATUS_OK) ?
                      jmip_pkg::ResultW'(app_sel) : '1;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.insert_offset = out_offset_q;
  assign out_o.status        = out_status_q;

endmodule
